>>> src/tbdd_pkg.sv
// tbdd_pkg: shared types and constants for the two-beam direction detector
// mode encoding, event codes, register indexes and register reset values
// no dependencies
package tbdd_pkg;

	localparam int unsigned TICK_W  = 16;
	localparam int unsigned ELAPSED_W = 17;
	localparam int unsigned EVENT_W = 2;
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

	localparam logic [TICK_W-1:0] TIMEOUT_RESET   = 16'd2000;
	localparam logic [TICK_W-1:0] CLEARANCE_RESET = 16'd300;

	typedef enum logic [1:0] {
		MODE_IDLE        = 2'd0,
		MODE_ARMED_OUTER = 2'd1,
		MODE_ARMED_INNER = 2'd2,
		MODE_LOCKED      = 2'd3
	} mode_t;

	typedef enum logic [EVENT_W-1:0] {
		EVENT_NONE    = 2'd0,
		EVENT_OPENING = 2'd1,
		EVENT_CLOSING = 2'd2
	} event_t;

	typedef enum logic {
		REG_TIMEOUT   = 1'b0,
		REG_CLEARANCE = 1'b1
	} reg_idx_t;

endpackage

>>> src/two_beam_direction_detector.sv
// two_beam_direction_detector: top level, apb register file and tick processing
// depends on tbdd_pkg
//
// usage:
//   input channel (in_valid/in_ready, outer_seen, inner_seen) takes one sampled
//   pair of beam levels per tick; each transaction yields exactly one result
//   transaction on the output channel (out_valid/out_ready, direction_event,
//   sequence_timed_out, rearmed)
//   an accepted item is held in the input register, the state update runs in the
//   logic between the input register and the result register, and the result is
//   offered from the result register
//   throughput is one item per cycle while the receiver does not stall
//   the result register and the input register form a two-entry pipe: while
//   the receiver stalls, one more item is taken and then in_ready drops
//   the user must write timeout_ticks (address 0) and clearance_ticks (address 4)
//   over the apb port while the block is idle (unenforced), pready is always high
//   reset clears the pipe, puts the detector in idle with a zero elapsed count
//   and loads the registers with 2000 and 300 ticks
module two_beam_direction_detector
	import tbdd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               outer_seen,
	input  logic               inner_seen,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [EVENT_W-1:0] direction_event,
	output logic               sequence_timed_out,
	output logic               rearmed
);

	logic [TICK_W-1:0]    timeout_q;
	logic [TICK_W-1:0]    clearance_q;
	mode_t                mode_q;
	mode_t                mode_d;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [ELAPSED_W-1:0] elapsed_d;
	logic [ELAPSED_W-1:0] elapsed_adv;

	logic    valid_s1;
	logic    outer_s1;
	logic    inner_s1;
	logic    advance_s1;
	logic    valid_s2;
	event_t  event_d;
	logic    timed_out_d;
	logic    rearmed_d;
	event_t  event_s2;
	logic    timed_out_s2;
	logic    rearmed_s2;
	reg_idx_t reg_sel;
	logic    wr_en;

	// register file
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[2]);
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= TIMEOUT_RESET;
			clearance_q <= CLEARANCE_RESET;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_TIMEOUT:   timeout_q   <= pwdata[TICK_W-1:0];
				REG_CLEARANCE: clearance_q <= pwdata[TICK_W-1:0];
				default:       timeout_q   <= timeout_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_TIMEOUT:   prdata = {{(PDATA_W-TICK_W){1'b0}}, timeout_q};
			REG_CLEARANCE: prdata = {{(PDATA_W-TICK_W){1'b0}}, clearance_q};
			default:       prdata = '0;
		endcase
	end

	// pipe control
	assign advance_s1 = valid_s1 & (~valid_s2 | out_ready);
	assign in_ready   = ~valid_s1 | advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			outer_s1 <= outer_seen;
			inner_s1 <= inner_seen;
		end
	end

	// tick state update
	assign elapsed_adv = (elapsed_q == ELAPSED_MAX) ? ELAPSED_MAX : elapsed_q + 1'b1;

	always_comb begin
		mode_d      = mode_q;
		elapsed_d   = elapsed_q;
		event_d     = EVENT_NONE;
		timed_out_d = 1'b0;
		rearmed_d   = 1'b0;
		unique case (mode_q)
			MODE_LOCKED: begin
				if (outer_s1 || inner_s1) begin
					elapsed_d = '0;
				end else begin
					elapsed_d = elapsed_adv;
					if (elapsed_adv > {1'b0, clearance_q}) begin
						mode_d    = MODE_IDLE;
						rearmed_d = 1'b1;
					end
				end
			end
			MODE_IDLE: begin
				if (outer_s1 && !inner_s1) begin
					mode_d    = MODE_ARMED_OUTER;
					elapsed_d = '0;
				end else if (inner_s1 && !outer_s1) begin
					mode_d    = MODE_ARMED_INNER;
					elapsed_d = '0;
				end
			end
			MODE_ARMED_OUTER, MODE_ARMED_INNER: begin
				elapsed_d = elapsed_adv;
				priority if (elapsed_adv > {1'b0, timeout_q}) begin
					mode_d      = MODE_IDLE;
					timed_out_d = 1'b1;
				end else if (mode_q == MODE_ARMED_OUTER && inner_s1) begin
					event_d   = EVENT_OPENING;
					mode_d    = MODE_LOCKED;
					elapsed_d = '0;
				end else if (mode_q == MODE_ARMED_INNER && outer_s1) begin
					event_d   = EVENT_CLOSING;
					mode_d    = MODE_LOCKED;
					elapsed_d = '0;
				end else begin
					mode_d = mode_q;
				end
			end
			default: mode_d = MODE_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			elapsed_q <= '0;
		end else if (advance_s1) begin
			mode_q    <= mode_d;
			elapsed_q <= elapsed_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			event_s2     <= event_d;
			timed_out_s2 <= timed_out_d;
			rearmed_s2   <= rearmed_d;
		end
	end

	assign out_valid          = valid_s2;
	assign direction_event    = event_s2;
	assign sequence_timed_out = timed_out_s2;
	assign rearmed            = rearmed_s2;

endmodule

>>> verif/tbdd_tracker_pkg.sv
// tbdd_tracker_pkg: expected-result tracker for the two-beam direction detector tests
// holds its own copy of the registers and detector state and queues the report of each tick
// depends on tbdd_pkg
package tbdd_tracker_pkg;
	import tbdd_pkg::*;

	typedef struct packed {
		event_t event_code;
		logic   timed_out;
		logic   rearmed;
	} beam_report_t;

	class direction_tracker;
		logic [TICK_W-1:0]    timeout_ticks;
		logic [TICK_W-1:0]    clearance_ticks;
		mode_t                mode;
		logic [ELAPSED_W-1:0] elapsed;
		beam_report_t         due_reports[$];
		int                   errors;

		function new();
			timeout_ticks   = TIMEOUT_RESET;
			clearance_ticks = CLEARANCE_RESET;
			mode            = MODE_IDLE;
			elapsed         = '0;
			errors          = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [PDATA_W-1:0] value);
			case (idx)
				REG_TIMEOUT: timeout_ticks = value[TICK_W-1:0];
				REG_CLEARANCE: clearance_ticks = value[TICK_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [ELAPSED_W-1:0] bumped();
			return (elapsed == ELAPSED_MAX) ? elapsed : elapsed + 1'b1;
		endfunction

		// one accepted tick: advance the detector and queue its report
		function void note_tick(logic outer, logic inner);
			beam_report_t r;
			r.event_code = EVENT_NONE;
			r.timed_out  = 1'b0;
			r.rearmed    = 1'b0;
			case (mode)
				MODE_LOCKED: begin
					if (outer || inner) begin
						elapsed = '0;
					end else begin
						elapsed = bumped();
						if (elapsed > {1'b0, clearance_ticks}) begin
							mode = MODE_IDLE;
							r.rearmed = 1'b1;
						end
					end
				end
				MODE_IDLE: begin
					if (outer && !inner) begin
						mode = MODE_ARMED_OUTER;
						elapsed = '0;
					end else if (inner && !outer) begin
						mode = MODE_ARMED_INNER;
						elapsed = '0;
					end
				end
				default: begin
					elapsed = bumped();
					if (elapsed > {1'b0, timeout_ticks}) begin
						mode = MODE_IDLE;
						r.timed_out = 1'b1;
					end else if (mode == MODE_ARMED_OUTER && inner) begin
						r.event_code = EVENT_OPENING;
						mode = MODE_LOCKED;
						elapsed = '0;
					end else if (mode == MODE_ARMED_INNER && outer) begin
						r.event_code = EVENT_CLOSING;
						mode = MODE_LOCKED;
						elapsed = '0;
					end
				end
			endcase
			due_reports.push_back(r);
		endfunction

		function int pending();
			return due_reports.size();
		endfunction

		function void check_report(logic [EVENT_W-1:0] ev, logic timed_out, logic rearmed);
			beam_report_t want;
			if (due_reports.size() == 0) begin
				errors++;
				$display("%0t: unexpected result transaction event=%0d timed_out=%0b rearmed=%0b",
					$time, ev, timed_out, rearmed);
				return;
			end
			want = due_reports.pop_front();
			if (ev !== want.event_code) begin
				errors++;
				$display("%0t: direction_event mismatch expected %0d actual %0d",
					$time, want.event_code, ev);
			end
			if (timed_out !== want.timed_out) begin
				errors++;
				$display("%0t: sequence_timed_out mismatch expected %0b actual %0b",
					$time, want.timed_out, timed_out);
			end
			if (rearmed !== want.rearmed) begin
				errors++;
				$display("%0t: rearmed mismatch expected %0b actual %0b",
					$time, want.rearmed, rearmed);
			end
		endfunction
	endclass

endpackage

>>> verif/tb_top.sv
// tb_top: self-checking test of two_beam_direction_detector over directed and random ticks
// drives the apb port and both valid/ready channels, checks each result transaction
// depends on tbdd_pkg, tbdd_tracker_pkg and the detector rtl
module tb_top;
	import tbdd_pkg::*;
	import tbdd_tracker_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES = 8;
	localparam int TICKS_PER_PHASE = 70;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic               outer_seen;
	logic               inner_seen;
	logic               out_valid;
	logic               out_ready;
	logic [EVENT_W-1:0] direction_event;
	logic               sequence_timed_out;
	logic               rearmed;

	direction_tracker book;
	int               send_idle_pct = 0;
	int               stall_pct = 0;
	int               sent_in_phase = 0;
	int               quiet_cycles = 0;

	int unsigned timeout_set[PHASES]   = '{2000, 4, 0, 65535, 12, 1, 30, 65535};
	int unsigned clearance_set[PHASES] = '{300, 3, 0, 65535, 8, 0, 20, 0};

	// {outer, inner} per tick
	logic [1:0] walk_a[18] = '{2'b11, 2'b00, 2'b10, 2'b00, 2'b01, 2'b11, 2'b00, 2'b00, 2'b01,
		2'b00, 2'b11, 2'b00, 2'b00, 2'b10, 2'b00, 2'b00, 2'b00, 2'b00};
	logic [1:0] walk_b[5] = '{2'b10, 2'b01, 2'b00, 2'b01, 2'b10};
	logic [1:0] walk_c[2] = '{2'b01, 2'b10};

	two_beam_direction_detector u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.outer_seen        (outer_seen),
		.inner_seen        (inner_seen),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.direction_event   (direction_event),
		.sequence_timed_out(sequence_timed_out),
		.rearmed           (rearmed)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			book.check_report(direction_event, sequence_timed_out, rearmed);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	function automatic int unsigned span(int unsigned v);
		return (v < 400) ? v + 2 : 40;
	endfunction

	task automatic apb_write(reg_idx_t idx, logic [TICK_W-1:0] value);
		logic [PDATA_W-1:0] word;
		word = {16'($urandom), value};
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		book.set_reg(idx, word);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_tick(logic outer, logic inner);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		outer_seen <= outer;
		inner_seen <= inner;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		book.note_tick(outer, inner);
		sent_in_phase++;
	endtask

	// hold off input until every queued report has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (book.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	// arm on one beam, wait, cross with the other (or both at once), then hold the lock and clear
	task automatic run_sequence();
		logic first_outer;
		int   gap_len;
		int   lock_len;
		int   clear_len;
		first_outer = 1'($urandom_range(1));
		send_tick(first_outer, !first_outer);
		gap_len = $urandom_range(span(book.timeout_ticks));
		repeat (gap_len) begin
			if ($urandom_range(3) == 0) send_tick(first_outer, !first_outer);
			else send_tick(1'b0, 1'b0);
		end
		if ($urandom_range(4) == 0) send_tick(1'b1, 1'b1);
		else send_tick(!first_outer, first_outer);
		lock_len = $urandom_range(3);
		repeat (lock_len) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
		clear_len = $urandom_range(span(book.clearance_ticks));
		repeat (clear_len) send_tick(1'b0, 1'b0);
	endtask

	initial begin
		int  pause_at;
		bit  paused;
		book = new();
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		outer_seen <= 1'b0;
		inner_seen <= 1'b0;
		out_ready <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed ticks
		apb_write(REG_TIMEOUT, 16'd3);
		apb_write(REG_CLEARANCE, 16'd1);
		foreach (walk_a[k]) send_tick(walk_a[k][1], walk_a[k][0]);
		drain();
		apb_write(REG_TIMEOUT, 16'd1);
		apb_write(REG_CLEARANCE, 16'd0);
		foreach (walk_b[k]) send_tick(walk_b[k][1], walk_b[k][0]);
		drain();
		apb_write(REG_TIMEOUT, 16'd0);
		foreach (walk_c[k]) send_tick(walk_c[k][1], walk_c[k][0]);

		// random phases
		for (int p = 0; p < PHASES; p++) begin
			drain();
			apb_write(REG_TIMEOUT, 16'(timeout_set[p]));
			apb_write(REG_CLEARANCE, 16'(clearance_set[p]));
			case (p % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 65; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 65; end
				default: begin send_idle_pct = 32; stall_pct = 32; end
			endcase
			sent_in_phase = 0;
			pause_at = $urandom_range(20, 60);
			paused = 1'b0;
			while (sent_in_phase < TICKS_PER_PHASE) begin
				if (!paused && sent_in_phase >= pause_at) begin
					drain();
					paused = 1'b1;
				end
				if ($urandom_range(9) < 8) begin
					run_sequence();
				end else begin
					repeat ($urandom_range(1, 4))
						send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
				end
			end
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (book.pending() != 0);
		repeat (8) @(posedge clk);
		if (book.errors == 0 && book.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

>>> two_beam_direction_detector.f
src/tbdd_pkg.sv
src/two_beam_direction_detector.sv
verif/tbdd_tracker_pkg.sv
verif/tb_top.sv
